### src/gww_pkg.sv
package gww_pkg;

  // Field widths
  localparam int unsigned CP_W      = 21;
  localparam int unsigned METRIC_W  = 18;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned W24       = 24;
  localparam int unsigned LH_W      = 17;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned ROW_W     = 25;
  localparam int unsigned CFG_IDX_W = 2;

  // Default position counter width
  localparam int unsigned POS_BITS_DEF = 16;

  // Register defaults
  localparam logic [W24-1:0]     MAX_WIDTH_RST   = 24'hFF_FFFF;
  localparam logic [W24-1:0]     MAX_HEIGHT_RST  = 24'hFF_FFFF;
  localparam logic [LH_W-1:0]    LINE_HEIGHT_RST = 17'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RST       = 16'd256;

  // Character codes
  localparam logic [CP_W-1:0] CP_NEWLINE = 21'd10;
  localparam logic [CP_W-1:0] CP_TAB     = 21'd9;
  localparam logic [CP_W-1:0] CP_CR      = 21'd13;
  localparam logic [CP_W-1:0] CP_SPACE   = 21'd32;

  // Opcodes and record kinds
  localparam logic OP_CHAR      = 1'b0;
  localparam logic OP_END       = 1'b1;
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_WIDTH   = 2'd0,
    CFG_MAX_HEIGHT  = 2'd1,
    CFG_LINE_HEIGHT = 2'd2,
    CFG_SCALE       = 2'd3
  } cfg_idx_e;

  // Unscaled record waiting for the scaling stage
  typedef struct packed {
    logic [IDX_W-1:0]        line_start;
    logic [IDX_W-1:0]        line_end;
    logic signed [ROW_W-1:0] line_raw;
    logic [IDX_W-1:0]        glyph_count;
    logic [W24-1:0]          height_raw;
  } rec_t;

  // Output register contents
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] line_start;
    logic [IDX_W-1:0] line_end;
    logic [W24-1:0]   line_width;
    logic [IDX_W-1:0] glyph_count;
    logic [W24-1:0]   text_width;
    logic [W24-1:0]   text_height;
    logic             last;
  } out_rec_t;

endpackage

### src/gww_if.sv
// Input channel: one code point and its glyph metrics per beat
interface gww_in_if;
  logic                                          valid;
  logic                                          ready;
  logic                                          op;
  logic        [gww_pkg::CP_W-1:0]               code_point;
  logic                                          glyph_found;
  logic signed [gww_pkg::METRIC_W-1:0]           glyph_advance;
  logic signed [gww_pkg::METRIC_W-1:0]           glyph_x_bearing;
  logic                                          glyph_visible;

  modport source (
    output valid, op, code_point, glyph_found, glyph_advance, glyph_x_bearing,
           glyph_visible,
    input  ready
  );
  modport sink (
    input  valid, op, code_point, glyph_found, glyph_advance, glyph_x_bearing,
           glyph_visible,
    output ready
  );
endinterface

// Output channel: one line record or summary per beat
interface gww_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [gww_pkg::IDX_W-1:0]   line_start;
  logic [gww_pkg::IDX_W-1:0]   line_end;
  logic [gww_pkg::W24-1:0]     line_width;
  logic [gww_pkg::IDX_W-1:0]   glyph_count;
  logic [gww_pkg::W24-1:0]     text_width;
  logic [gww_pkg::W24-1:0]     text_height;
  logic                        last;

  modport source (
    output valid, kind, line_start, line_end, line_width, glyph_count, text_width,
           text_height, last,
    input  ready
  );
  modport sink (
    input  valid, kind, line_start, line_end, line_width, glyph_count, text_width,
           text_height, last,
    output ready
  );
endinterface

### src/greedy_word_wrap_measure_core.sv
// Greedy word-wrap measurement. Each input beat is one code point with its glyph metrics
// (op 0) or an end-of-text marker (op 1). The block keeps the row and word state and emits a
// line record whenever a newline arrives or the row would exceed max_width, breaking after the
// last whole word; the end marker flushes the last row and emits a summary, then clears the
// state for the next text. A character beat is taken every cycle when not back-pressured: its
// state update is done in the accept cycle and its record, if any, moves through a one-entry
// record stage into a single-multiplier scaling stage, then the output register. An end beat
// that flushes a row yields two records and stalls the next beat. Character beats after a
// glyph wider than the row, or after the height limit is reached, are dropped without a record
// until the next end beat. Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the block is idle: a user rule that the block does not enforce.
module greedy_word_wrap_measure_core #(
  parameter int unsigned POS_BITS = gww_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gww_pkg::W24-1:0]         cfg_data_i,
  gww_in_if.sink                          in_i,
  gww_out_if.source                       out_o
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [gww_pkg::IDX_W-1:0] CNT_MAX = {gww_pkg::IDX_W{1'b1}};
  localparam logic signed [26:0] ROW_HI = 27'sd16777215;
  localparam logic signed [26:0] ROW_LO = -27'sd16777216;

  // Configuration registers
  logic [gww_pkg::W24-1:0]     max_width_q, max_height_q;
  logic [gww_pkg::LH_W-1:0]    line_height_q;
  logic [gww_pkg::SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q   <= gww_pkg::MAX_WIDTH_RST;
      max_height_q  <= gww_pkg::MAX_HEIGHT_RST;
      line_height_q <= gww_pkg::LINE_HEIGHT_RST;
      scale_q       <= gww_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (gww_pkg::cfg_idx_e'(cfg_idx_i))
        gww_pkg::CFG_MAX_WIDTH:   max_width_q   <= cfg_data_i;
        gww_pkg::CFG_MAX_HEIGHT:  max_height_q  <= cfg_data_i;
        gww_pkg::CFG_LINE_HEIGHT: line_height_q <= cfg_data_i[gww_pkg::LH_W-1:0];
        gww_pkg::CFG_SCALE:       scale_q       <= cfg_data_i[gww_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Wrap state
  logic [POS_BITS-1:0]              char_pos_q, char_pos_d;
  logic [POS_BITS-1:0]              word_start_pos_q, word_start_pos_d;
  logic [POS_BITS-1:0]              word_end_pos_q, word_end_pos_d;
  logic [POS_BITS-1:0]              line_begin_q, line_begin_d;
  logic signed [gww_pkg::ROW_W-1:0] row_width_q, row_width_d;
  logic signed [gww_pkg::ROW_W-1:0] word_start_width_q, word_start_width_d;
  logic signed [gww_pkg::ROW_W-1:0] word_end_width_q, word_end_width_d;
  logic                             word_open_q, word_open_d;
  logic                             word_end_valid_q, word_end_valid_d;
  logic                             first_in_row_q, first_in_row_d;
  logic                             stopped_q, stopped_d;
  logic [gww_pkg::IDX_W-1:0]        visible_count_q, visible_count_d;
  logic [gww_pkg::W24-1:0]          height_acc_q, height_acc_d;

  // Record stage and output stage
  logic            rec_line_q, rec_line_d, rec_sum_q, rec_sum_d;
  gww_pkg::rec_t   rec_q, rec_d;
  logic            load_line, load_sum;
  gww_pkg::rec_t   load_rec;
  logic            out_v_q;
  gww_pkg::out_rec_t out_q;
  logic [gww_pkg::W24-1:0] widest_q;

  logic in_acc, pop, rec_busy;

  assign rec_busy = rec_line_q | rec_sum_q;
  assign pop      = rec_busy & (~out_v_q | out_o.ready);
  assign in_i.ready = ~rec_busy | (pop & ~(rec_line_q & rec_sum_q));
  assign in_acc   = in_i.valid & in_i.ready;

  // Per-character working values
  logic [POS_BITS-1:0]              p_next, text_pos, lend;
  logic                             advanced, nl, wo, sp;
  logic signed [gww_pkg::ROW_W-1:0] lraw;
  logic signed [18:0]               w;
  logic signed [25:0]               max_w_s, row_sum;
  logic signed [26:0]               row_shift;
  logic [24:0]                      ha_lh, ha2_lh;
  logic [gww_pkg::W24-1:0]          ha_new;

  assign max_w_s = $signed({2'b00, max_width_q});
  assign p_next  = (char_pos_q != POS_MAX) ? char_pos_q + 1'b1 : char_pos_q;
  assign ha_lh   = {1'b0, height_acc_q} + 25'(line_height_q);
  assign ha_new  = ha_lh[24] ? {gww_pkg::W24{1'b1}} : ha_lh[23:0];
  assign ha2_lh  = {1'b0, ha_new} + 25'(line_height_q);

  // State update for one accepted beat
  always_comb begin
    char_pos_d         = char_pos_q;
    word_start_pos_d   = word_start_pos_q;
    word_end_pos_d     = word_end_pos_q;
    line_begin_d       = line_begin_q;
    row_width_d        = row_width_q;
    word_start_width_d = word_start_width_q;
    word_end_width_d   = word_end_width_q;
    word_open_d        = word_open_q;
    word_end_valid_d   = word_end_valid_q;
    first_in_row_d     = first_in_row_q;
    stopped_d          = stopped_q;
    visible_count_d    = visible_count_q;
    height_acc_d       = height_acc_q;
    load_line          = 1'b0;
    load_sum           = 1'b0;
    load_rec           = '0;
    text_pos           = char_pos_q;
    lend               = char_pos_q;
    advanced           = 1'b0;
    nl                 = 1'b0;
    wo                 = word_open_q;
    lraw               = '0;
    w                  = '0;
    row_sum            = '0;
    row_shift          = '0;
    sp                 = (in_i.code_point == gww_pkg::CP_SPACE) ||
                         ((in_i.code_point >= gww_pkg::CP_TAB) &&
                          (in_i.code_point <= gww_pkg::CP_CR));

    if (in_acc) begin
      if (in_i.op == gww_pkg::OP_END) begin
        // Flush the open row if it fits, then summary and clear
        load_line            = word_open_q && (ha_lh <= {1'b0, max_height_q});
        load_sum             = 1'b1;
        load_rec.line_start  = gww_pkg::IDX_W'(line_begin_q);
        load_rec.line_end    = gww_pkg::IDX_W'(char_pos_q);
        load_rec.line_raw    = row_width_q;
        load_rec.glyph_count = visible_count_q;
        load_rec.height_raw  = load_line ? ha_new : height_acc_q;
        char_pos_d           = '0;
        word_start_pos_d     = '0;
        word_end_pos_d       = '0;
        line_begin_d         = '0;
        row_width_d          = '0;
        word_start_width_d   = '0;
        word_end_width_d     = '0;
        word_open_d          = 1'b0;
        word_end_valid_d     = 1'b0;
        first_in_row_d       = 1'b1;
        stopped_d            = 1'b0;
        visible_count_d      = '0;
        height_acc_d         = '0;
      end else if (!stopped_q) begin
        if (in_i.code_point == gww_pkg::CP_NEWLINE) begin
          lraw        = row_width_q;
          row_width_d = '0;
          wo          = 1'b0;
          nl          = 1'b1;
          text_pos    = p_next;
          advanced    = 1'b1;
          word_open_d = 1'b0;
        end else begin
          if (in_i.glyph_found) begin
            w = 19'(in_i.glyph_advance);
            if (in_i.glyph_visible && (visible_count_q != CNT_MAX)) begin
              visible_count_d = visible_count_q + 1'b1;
            end
            if (first_in_row_q) begin
              w              = 19'(in_i.glyph_advance) - 19'(in_i.glyph_x_bearing);
              first_in_row_d = 1'b0;
            end
          end
          if (26'(w) > max_w_s) begin
            // Glyph wider than the row: stop without a record
            word_open_d = 1'b0;
            stopped_d   = 1'b1;
          end else begin
            // Word boundary tracking
            if (wo == sp) begin
              if (wo) begin
                word_end_width_d = row_width_q;
                word_end_pos_d   = char_pos_q;
                word_end_valid_d = 1'b1;
                wo               = 1'b0;
              end else begin
                word_start_width_d = row_width_q;
                word_start_pos_d   = char_pos_q;
                wo                 = 1'b1;
              end
            end
            row_sum = 26'(row_width_q) + 26'(w);
            if (row_sum > max_w_s) begin
              // Row overflow: break after the last whole word if any
              nl = 1'b1;
              if (word_end_valid_d && (word_end_pos_d > line_begin_q)) begin
                lraw = word_end_width_d;
                lend = word_end_pos_d;
                if (wo) begin
                  row_shift = 27'(row_width_q) - 27'(word_start_width_d) + 27'(w);
                  if (row_shift > ROW_HI) begin
                    row_width_d = ROW_HI[24:0];
                  end else if (row_shift < ROW_LO) begin
                    row_width_d = ROW_LO[24:0];
                  end else begin
                    row_width_d = row_shift[24:0];
                  end
                end else begin
                  row_width_d = 25'(w);
                end
              end else begin
                lraw        = row_width_q;
                lend        = char_pos_q;
                row_width_d = 25'(w);
                if (!sp) begin
                  wo               = 1'b1;
                  word_start_pos_d = char_pos_q;
                end
              end
              if (!wo && sp) begin
                text_pos = p_next;
                advanced = 1'b1;
              end
            end else begin
              // row_sum stays within 26 bits; clamp to the 25-bit range
              if (27'(row_sum) > ROW_HI) begin
                row_width_d = ROW_HI[24:0];
              end else if (27'(row_sum) < ROW_LO) begin
                row_width_d = ROW_LO[24:0];
              end else begin
                row_width_d = row_sum[24:0];
              end
            end
            word_open_d = wo;
          end
        end

        if (nl) begin
          load_line            = 1'b1;
          load_rec.line_start  = gww_pkg::IDX_W'(line_begin_q);
          load_rec.line_end    = gww_pkg::IDX_W'(lend);
          load_rec.line_raw    = lraw;
          load_rec.glyph_count = visible_count_d;
          load_rec.height_raw  = '0;
          line_begin_d         = wo ? word_start_pos_d : text_pos;
          height_acc_d         = ha_new;
          if (ha2_lh >= {1'b0, max_height_q}) begin
            stopped_d  = 1'b1;
            char_pos_d = text_pos;
          end else begin
            first_in_row_d = 1'b1;
            char_pos_d     = advanced ? text_pos : p_next;
          end
        end else if (!stopped_d) begin
          char_pos_d = p_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q         <= '0;
      word_start_pos_q   <= '0;
      word_end_pos_q     <= '0;
      line_begin_q       <= '0;
      row_width_q        <= '0;
      word_start_width_q <= '0;
      word_end_width_q   <= '0;
      word_open_q        <= 1'b0;
      word_end_valid_q   <= 1'b0;
      first_in_row_q     <= 1'b1;
      stopped_q          <= 1'b0;
      visible_count_q    <= '0;
      height_acc_q       <= '0;
    end else begin
      char_pos_q         <= char_pos_d;
      word_start_pos_q   <= word_start_pos_d;
      word_end_pos_q     <= word_end_pos_d;
      line_begin_q       <= line_begin_d;
      row_width_q        <= row_width_d;
      word_start_width_q <= word_start_width_d;
      word_end_width_q   <= word_end_width_d;
      word_open_q        <= word_open_d;
      word_end_valid_q   <= word_end_valid_d;
      first_in_row_q     <= first_in_row_d;
      stopped_q          <= stopped_d;
      visible_count_q    <= visible_count_d;
      height_acc_q       <= height_acc_d;
    end
  end

  // Record stage: a line goes out before the summary of the same beat
  always_comb begin
    rec_line_d = rec_line_q;
    rec_sum_d  = rec_sum_q;
    rec_d      = rec_q;
    if (pop) begin
      if (rec_line_q) begin
        rec_line_d = 1'b0;
      end else begin
        rec_sum_d = 1'b0;
      end
    end
    if (load_line || load_sum) begin
      rec_line_d = load_line;
      rec_sum_d  = load_sum;
      rec_d      = load_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_line_q <= 1'b0;
      rec_sum_q  <= 1'b0;
    end else begin
      rec_line_q <= rec_line_d;
      rec_sum_q  <= rec_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  // Scaling: (w * scale + 128) >> 8, zero for w <= 0, saturated to 24 bits
  logic signed [gww_pkg::ROW_W-1:0] sc_in;
  logic [39:0]                      sc_prod;
  logic [40:0]                      sc_round;
  logic [gww_pkg::W24-1:0]          sc_out, widest_new;

  assign sc_in    = rec_line_q ? rec_q.line_raw : $signed({1'b0, rec_q.height_raw});
  assign sc_prod  = sc_in[23:0] * scale_q;
  assign sc_round = {1'b0, sc_prod} + 41'd128;
  always_comb begin
    if (sc_in <= 0) begin
      sc_out = '0;
    end else if (|sc_round[40:32]) begin
      sc_out = {gww_pkg::W24{1'b1}};
    end else begin
      sc_out = sc_round[31:8];
    end
  end
  assign widest_new = (sc_out > widest_q) ? sc_out : widest_q;

  // Output register and running maximum line width
  gww_pkg::out_rec_t out_d;
  always_comb begin
    out_d             = '0;
    out_d.glyph_count = rec_q.glyph_count;
    if (rec_line_q) begin
      out_d.kind       = gww_pkg::KIND_LINE;
      out_d.line_start = rec_q.line_start;
      out_d.line_end   = rec_q.line_end;
      out_d.line_width = sc_out;
      out_d.text_width = widest_new;
      out_d.last       = ~rec_sum_q;
    end else begin
      out_d.kind        = gww_pkg::KIND_SUMMARY;
      out_d.text_width  = widest_q;
      out_d.text_height = sc_out;
      out_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      widest_q <= '0;
    end else begin
      if (pop) begin
        out_v_q  <= 1'b1;
        widest_q <= rec_line_q ? widest_new : '0;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.line_start  = out_q.line_start;
  assign out_o.line_end    = out_q.line_end;
  assign out_o.line_width  = out_q.line_width;
  assign out_o.glyph_count = out_q.glyph_count;
  assign out_o.text_width  = out_q.text_width;
  assign out_o.text_height = out_q.text_height;
  assign out_o.last        = out_q.last;

  // Checks
  a_ready_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> rec_busy)
    else $error("input stalled with an empty record stage");

  a_summary_clears_widest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !rec_line_q) |=> (widest_q == '0))
    else $error("widest line not cleared after summary");

  a_summary_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind == gww_pkg::KIND_SUMMARY)) |->
      ((out_q.line_width == '0) && out_q.last))
    else $error("summary beat carries line data or is not last");

  a_stopped_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.op == gww_pkg::OP_CHAR) && stopped_q) |=>
      ($stable(char_pos_q) && !rec_line_q))
    else $error("character beat changed state while stopped");

endmodule

### tb/tb.sv
module tb;

  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 45;
  localparam int LONG_TEXT      = 100;

  typedef logic [gww_pkg::CP_W-1:0]            cp_t;
  typedef logic signed [gww_pkg::METRIC_W-1:0] metric_t;
  typedef logic [gww_pkg::W24-1:0]             w24_t;

  // One input beat: a code point with its metrics, or the end-of-text marker
  typedef struct {
    logic    op;
    cp_t     code_point;
    logic    glyph_found;
    metric_t glyph_advance;
    metric_t glyph_x_bearing;
    logic    glyph_visible;
  } glyph_beat_t;

  // Word-wrap measurement tracker: mirrors the row/word state and queues the
  // line and summary records each accepted beat should produce
  class line_wrap_tracker;
    localparam longint POS_MAX = (longint'(1) << gww_pkg::POS_BITS_DEF) - 1;
    localparam longint W24_MAX = 16777215;

    longint max_width, max_height, line_height, scale;
    longint char_pos, word_start_pos, word_end_pos, line_begin;
    longint row_width, word_start_width, word_end_width;
    bit word_open, word_end_valid, first_in_row, stopped;
    longint visible_count, widest_line, height_acc;
    gww_pkg::out_rec_t pending_records[$];
    int unsigned errors;

    function void clear_text();
      char_pos = 0; word_start_pos = 0; word_end_pos = 0; line_begin = 0;
      row_width = 0; word_start_width = 0; word_end_width = 0;
      word_open = 0; word_end_valid = 0; first_in_row = 1; stopped = 0;
      visible_count = 0; widest_line = 0; height_acc = 0;
    endfunction

    function void reset_all();
      max_width   = longint'(gww_pkg::MAX_WIDTH_RST);
      max_height  = longint'(gww_pkg::MAX_HEIGHT_RST);
      line_height = longint'(gww_pkg::LINE_HEIGHT_RST);
      scale       = longint'(gww_pkg::SCALE_RST);
      errors      = 0;
      clear_text();
    endfunction

    function void set_reg(gww_pkg::cfg_idx_e idx, w24_t data);
      case (idx)
        gww_pkg::CFG_MAX_WIDTH:   max_width = longint'(data);
        gww_pkg::CFG_MAX_HEIGHT:  max_height = longint'(data);
        gww_pkg::CFG_LINE_HEIGHT: line_height = longint'(data[gww_pkg::LH_W-1:0]);
        gww_pkg::CFG_SCALE:       scale = longint'(data[gww_pkg::SCALE_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint sat_row(longint v);
      if (v > W24_MAX) return W24_MAX;
      if (v < -16777216) return -16777216;
      return v;
    endfunction

    function longint sat_w24(longint v);
      return (v > W24_MAX) ? W24_MAX : v;
    endfunction

    function longint next_pos(longint p);
      return (p < POS_MAX) ? p + 1 : p;
    endfunction

    // Q8.8 scaling, round half up, zero for non-positive widths
    function longint to_scaled(longint w);
      if (w <= 0) return 0;
      return sat_w24((w * scale + 128) >>> 8);
    endfunction

    function void add_record(logic kind, longint s_pos, longint e_pos, longint lw,
                             longint th, logic last);
      gww_pkg::out_rec_t r;
      r.kind        = kind;
      r.line_start  = s_pos[gww_pkg::IDX_W-1:0];
      r.line_end    = e_pos[gww_pkg::IDX_W-1:0];
      r.line_width  = lw[gww_pkg::W24-1:0];
      r.glyph_count = visible_count[gww_pkg::IDX_W-1:0];
      r.text_width  = widest_line[gww_pkg::W24-1:0];
      r.text_height = th[gww_pkg::W24-1:0];
      r.last        = last;
      pending_records.insert(pending_records.size(), r);
    endfunction

    function void fold_beat(glyph_beat_t b);
      longint p, text, lend, lraw, w, lw;
      bit advanced, nl, sp;

      // End of text: flush the open row if it fits, then the summary
      if (b.op == gww_pkg::OP_END) begin
        if (word_open && height_acc + line_height <= max_height) begin
          lw = to_scaled(row_width);
          if (lw > widest_line) widest_line = lw;
          height_acc = sat_w24(height_acc + line_height);
          add_record(gww_pkg::KIND_LINE, line_begin, char_pos, lw, 0, 1'b0);
        end
        add_record(gww_pkg::KIND_SUMMARY, 0, 0, 0, to_scaled(height_acc), 1'b1);
        clear_text();
        return;
      end
      if (stopped) return;

      p = char_pos; text = p; lend = p; lraw = 0;
      advanced = 0; nl = 0;
      if (b.code_point == gww_pkg::CP_NEWLINE) begin
        lraw = row_width;
        row_width = 0;
        word_open = 0;
        nl = 1;
        text = next_pos(p);
        advanced = 1;
      end else begin
        w = 0;
        sp = (b.code_point == gww_pkg::CP_SPACE) ||
             (b.code_point >= gww_pkg::CP_TAB && b.code_point <= gww_pkg::CP_CR);
        if (b.glyph_found) begin
          w = longint'(b.glyph_advance);
          if (b.glyph_visible && visible_count < POS_MAX) visible_count++;
          if (first_in_row) begin
            w -= longint'(b.glyph_x_bearing);
            first_in_row = 0;
          end
        end
        // glyph wider than the whole row: stop silently
        if (w > max_width) begin
          word_open = 0;
          stopped = 1;
          return;
        end
        // word boundary tracking
        if (word_open == sp) begin
          if (word_open) begin
            word_end_width = row_width;
            word_end_pos = p;
            word_end_valid = 1;
            word_open = 0;
          end else begin
            word_start_width = row_width;
            word_start_pos = p;
            word_open = 1;
          end
        end
        // overflow: break after the last whole word, else mid-word
        if (row_width + w > max_width) begin
          nl = 1;
          if (word_end_valid && word_end_pos > line_begin) begin
            lraw = word_end_width;
            lend = word_end_pos;
            row_width = word_open ? sat_row(row_width - word_start_width + w) : w;
          end else begin
            lraw = row_width;
            lend = p;
            row_width = w;
            if (!sp) begin
              word_open = 1;
              word_start_pos = p;
            end
          end
          // a space that opens the new row is dropped
          if (!word_open && sp) begin
            text = next_pos(p);
            advanced = 1;
          end
        end else begin
          row_width = sat_row(row_width + w);
        end
      end

      if (nl) begin
        lw = to_scaled(lraw);
        if (lw > widest_line) widest_line = lw;
        add_record(gww_pkg::KIND_LINE, line_begin, lend, lw, 0, 1'b1);
        line_begin = word_open ? word_start_pos : text;
        height_acc = sat_w24(height_acc + line_height);
        if (height_acc + line_height >= max_height) begin
          stopped = 1;
          char_pos = text;
          return;
        end
        first_in_row = 1;
      end
      char_pos = advanced ? text : next_pos(p);
    endfunction

    function void report_field(string field, w24_t want_v, w24_t got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void match_record(gww_pkg::out_rec_t got);
      gww_pkg::out_rec_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, got kind %0d start %0d end %0d",
                 $time, got.kind, got.line_start, got.line_end);
        return;
      end
      want = pending_records.pop_front();
      report_field("kind", w24_t'(want.kind), w24_t'(got.kind));
      report_field("line_start", w24_t'(want.line_start), w24_t'(got.line_start));
      report_field("line_end", w24_t'(want.line_end), w24_t'(got.line_end));
      report_field("line_width", want.line_width, got.line_width);
      report_field("glyph_count", w24_t'(want.glyph_count), w24_t'(got.glyph_count));
      report_field("text_width", want.text_width, got.text_width);
      report_field("text_height", want.text_height, got.text_height);
      report_field("last", w24_t'(want.last), w24_t'(got.last));
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [gww_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  w24_t                          cfg_data_i;

  gww_in_if  in_ch ();
  gww_out_if out_ch ();

  line_wrap_tracker tracker;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  greedy_word_wrap_measure_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Result checking and watchdog
  always @(posedge clk_i) begin : watch_outputs
    gww_pkg::out_rec_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind        = out_ch.kind;
        got.line_start  = out_ch.line_start;
        got.line_end    = out_ch.line_end;
        got.line_width  = out_ch.line_width;
        got.glyph_count = out_ch.glyph_count;
        got.text_width  = out_ch.text_width;
        got.text_height = out_ch.text_height;
        got.last        = out_ch.last;
        tracker.match_record(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Drive one beat with random sender gaps; returns after the accepting edge
  task automatic push_beat(glyph_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           = 1'b1;
    in_ch.op              = b.op;
    in_ch.code_point      = b.code_point;
    in_ch.glyph_found     = b.glyph_found;
    in_ch.glyph_advance   = b.glyph_advance;
    in_ch.glyph_x_bearing = b.glyph_x_bearing;
    in_ch.glyph_visible   = b.glyph_visible;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tracker.fold_beat(b);
  endtask

  task automatic send_glyph(cp_t cp, int adv, int xb, logic found, logic vis);
    glyph_beat_t b;
    b.op              = gww_pkg::OP_CHAR;
    b.code_point      = cp;
    b.glyph_found     = found;
    b.glyph_advance   = adv[gww_pkg::METRIC_W-1:0];
    b.glyph_x_bearing = xb[gww_pkg::METRIC_W-1:0];
    b.glyph_visible   = vis;
    push_beat(b);
  endtask

  // End marker; the other fields carry noise
  task automatic send_end();
    glyph_beat_t b;
    int unsigned rnd;
    rnd = $urandom();
    b.op              = gww_pkg::OP_END;
    b.code_point      = cp_t'($urandom_range(0, 1114111));
    b.glyph_found     = rnd[0];
    b.glyph_visible   = rnd[1];
    b.glyph_advance   = metric_t'($urandom());
    b.glyph_x_bearing = metric_t'($urandom());
    push_beat(b);
  endtask

  function automatic glyph_beat_t random_glyph(int adv_max);
    glyph_beat_t b;
    int r, adv, xb;
    b.op = gww_pkg::OP_CHAR;
    r = $urandom_range(0, 99);
    if (r < 60) b.code_point = cp_t'($urandom_range(33, 126));
    else if (r < 68) b.code_point = cp_t'($urandom_range(127, 1114111));
    else if (r < 80) b.code_point = gww_pkg::CP_SPACE;
    else if (r < 85) b.code_point = cp_t'($urandom_range(gww_pkg::CP_TAB, gww_pkg::CP_CR));
    else if (r < 90) b.code_point = gww_pkg::CP_NEWLINE;
    else b.code_point = cp_t'($urandom_range(0, 1114111));
    b.glyph_found = ($urandom_range(0, 99) < 92);
    r = $urandom_range(0, 99);
    if (r < 85) adv = $urandom_range(0, adv_max);
    else if (r < 95) adv = -int'($urandom_range(0, 64));
    else adv = $urandom();
    xb = ($urandom_range(0, 99) < 90) ? int'($urandom_range(0, 64)) - 32 : int'($urandom());
    b.glyph_advance   = adv[gww_pkg::METRIC_W-1:0];
    b.glyph_x_bearing = xb[gww_pkg::METRIC_W-1:0];
    b.glyph_visible   = ($urandom_range(0, 99) < 80);
    return b;
  endfunction

  // Stop sending and let every expected record drain
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (tracker.pending_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(gww_pkg::cfg_idx_e idx, w24_t data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_config(w24_t mw, w24_t mh, w24_t lh, w24_t sc);
    write_reg(gww_pkg::CFG_MAX_WIDTH, mw);
    write_reg(gww_pkg::CFG_MAX_HEIGHT, mh);
    write_reg(gww_pkg::CFG_LINE_HEIGHT, lh);
    write_reg(gww_pkg::CFG_SCALE, sc);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Register setting for one random phase; first of each pass is an extreme
  function automatic void pick_setting(int mode, int k, output w24_t mw, output w24_t mh,
                                       output w24_t lh, output w24_t sc, output int adv_max);
    if (k == 0 && mode == 0) begin
      mw = 0; mh = gww_pkg::MAX_WIDTH_RST; lh = 131071; sc = 0; adv_max = 64;
    end else if (k == 0 && mode == 1) begin
      mw = gww_pkg::MAX_WIDTH_RST; mh = 0; lh = 0; sc = 65535; adv_max = 4096;
    end else if (k == 0) begin
      mw = gww_pkg::MAX_WIDTH_RST; mh = gww_pkg::MAX_HEIGHT_RST;
      lh = w24_t'(gww_pkg::LINE_HEIGHT_RST); sc = 65535;
      adv_max = 131071;
    end else begin
      mw = w24_t'($urandom_range(256, 6000));
      lh = w24_t'($urandom_range(64, 2048));
      mh = (k == 5) ? gww_pkg::MAX_HEIGHT_RST :
           w24_t'(lh * $urandom_range(1, 14) + $urandom_range(0, lh));
      sc = w24_t'($urandom_range(16, 1024));
      adv_max = int'(mw) / 5 + 1;
    end
  endfunction

  // Short texts under a narrow row to hit each break rule
  task automatic directed_checks();
    // extremes under the reset setting
    send_glyph(65, 131071, -131072, 1'b1, 1'b1);
    send_glyph(1114111, -131072, 131071, 1'b1, 1'b1);
    send_glyph(0, -1, 5, 1'b0, 1'b1);
    send_glyph(gww_pkg::CP_SPACE, 64, 0, 1'b1, 1'b0);
    send_glyph(gww_pkg::CP_TAB, 64, 0, 1'b1, 1'b1);
    send_glyph(gww_pkg::CP_NEWLINE, 0, 0, 1'b0, 1'b0);
    send_end();
    settle();
    apply_config(640, 3000, 1024, 512);
    // space at the break is skipped: "abc d"
    send_glyph(97, 192, 0, 1'b1, 1'b1);
    send_glyph(98, 192, 0, 1'b1, 1'b1);
    send_glyph(99, 192, 0, 1'b1, 1'b1);
    send_glyph(gww_pkg::CP_SPACE, 192, 0, 1'b1, 1'b0);
    send_glyph(100, 192, 0, 1'b1, 1'b1);
    send_end();
    // word break, newline, then height limit stops the text
    send_glyph(97, 192, 0, 1'b1, 1'b1);
    send_glyph(98, 192, 0, 1'b1, 1'b1);
    send_glyph(gww_pkg::CP_SPACE, 192, 0, 1'b1, 1'b0);
    send_glyph(99, 192, 0, 1'b1, 1'b1);
    send_glyph(100, 192, 0, 1'b1, 1'b1);
    send_glyph(gww_pkg::CP_NEWLINE, 0, 0, 1'b0, 1'b0);
    send_glyph(122, 192, 0, 1'b1, 1'b1);
    send_end();
    // glyph wider than the row
    send_glyph(113, 1000, 0, 1'b1, 1'b1);
    send_glyph(114, 192, 0, 1'b1, 1'b1);
    send_end();
    // single long word broken mid-word
    send_glyph(101, 192, 0, 1'b1, 1'b1);
    send_glyph(102, 192, 0, 1'b1, 1'b1);
    send_glyph(103, 192, 0, 1'b1, 1'b1);
    send_glyph(104, 192, 0, 1'b1, 1'b1);
    send_end();
  endtask

  // A long text: the row width saturates at its negative end first
  task automatic long_text();
    settle();
    apply_config(gww_pkg::MAX_WIDTH_RST, gww_pkg::MAX_HEIGHT_RST, 1, 256);
    repeat (130) send_glyph(65, -131072, 0, 1'b1, 1'b1);
    send_glyph(gww_pkg::CP_NEWLINE, 0, 0, 1'b0, 1'b0);
    for (int i = 0; i < LONG_TEXT; i++) begin
      if (i % 100 == 99) begin
        send_glyph(gww_pkg::CP_NEWLINE, 0, 0, 1'b0, 1'b0);
      end else if (i % 7 == 6) begin
        send_glyph(gww_pkg::CP_SPACE, int'($urandom_range(0, 64)), 0, 1'b1, 1'b1);
      end else begin
        send_glyph(cp_t'($urandom_range(33, 126)), int'($urandom_range(0, 64)), 0,
                   1'b1, 1'b1);
      end
    end
    send_end();
  endtask

  initial begin : main
    w24_t mw, mh, lh, sc;
    int adv_max, counted, len;

    tracker = new();
    tracker.reset_all();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = gww_pkg::CFG_MAX_WIDTH;
    cfg_data_i            = '0;
    in_ch.valid           = 1'b0;
    in_ch.op              = gww_pkg::OP_CHAR;
    in_ch.code_point      = '0;
    in_ch.glyph_found     = 1'b0;
    in_ch.glyph_advance   = '0;
    in_ch.glyph_x_bearing = '0;
    in_ch.glyph_visible   = 1'b0;
    out_ch.ready          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_checks();

    // random texts: receiver-heavy idling, sender-heavy idling, then none
    for (int mode = 0; mode < 3; mode++) begin
      for (int k = 0; k < 6; k++) begin
        settle();
        in_idle_pct  = (mode == 0) ? 31 : (mode == 1) ? 73 : 0;
        out_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 31 : 0;
        pick_setting(mode, k, mw, mh, lh, sc, adv_max);
        apply_config(mw, mh, lh, sc);
        counted = 0;
        while (counted < PHASE_ITEMS) begin
          len = $urandom_range(1, 60);
          for (int i = 0; i < len; i++) begin
            push_beat(random_glyph(adv_max));
            counted++;
          end
          send_end();
          counted++;
        end
      end
    end

    long_text();
    settle();
    if (tracker.errors == 0 && tracker.pending_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/gww_pkg.sv
src/gww_if.sv
src/greedy_word_wrap_measure_core.sv
tb/tb.sv
